FILE: rtl/core/lgsw_pkg.sv
// lgsw_pkg: shared widths, register codes and constant helpers
// for the lagrange grid spread weights block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lgsw_pkg;

  // field and datapath widths
  localparam int COORD_W    = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int NBCFG_W    = 6;
  localparam int GIDX_W     = 14;
  localparam int WEIGHT_W   = 20;
  localparam int U_W        = 23;
  localparam int V_W        = 28;
  localparam int ACC_W      = 36;
  localparam int BASIS_W    = 32;
  localparam int P_W        = 65;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ORIGIN    = 2'd0,
    REG_INV_BOX_WIDTH  = 2'd1,
    REG_BOXES_PER_SIDE = 2'd2
  } cfg_reg_t;

  // magnitude of the basis denominator: product of 2|j-k| over k != j
  function automatic longint den_mag(input int j, input int n);
    longint r;
    r = 1;
    for (int k = 0; k < n; k++) begin
      if (k != j) begin
        r = r * 2 * ((j > k) ? (j - k) : (k - j));
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lgsw_locate.sv
// lgsw_locate: three-stage box lookup for one axis (offset, scale, split)
// depends on lgsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgsw_locate #(
  parameter int MAX_BOXES = 32,
  localparam int NB_W = $clog2(MAX_BOXES + 1),
  localparam int BX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic [lgsw_pkg::COORD_W-1:0]  coord_i,
  input  logic [lgsw_pkg::CFG_W-1:0]    origin_i,
  input  logic [lgsw_pkg::CFG_W-1:0]    inv_i,
  input  logic [NB_W-1:0]               nb_i,
  output logic                          valid_o,
  output logic [BX_W-1:0]               box_o,
  output logic signed [lgsw_pkg::U_W-1:0] u_o
);
  import lgsw_pkg::*;

  localparam logic [48:0] U_LIM = 49'd1 << 22;

  logic               v1_r, v2_r, v3_r;
  logic signed [32:0] d_r, d_nxt;
  logic               neg_r;
  logic [P_W-1:0]     p_r, p_nxt;
  logic [32:0]        mag;
  logic [BX_W-1:0]    box_r, box_nxt;
  logic signed [U_W-1:0] u_r, u_nxt;
  logic [32:0]        idx;
  logic [NB_W-1:0]    nbm1;
  logic [48:0]        q16, upos, mneg;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: offset from the grid origin
  assign d_nxt = $signed({coord_i[31], coord_i}) - $signed({origin_i[31], origin_i});

  // stage 2: magnitude times reciprocal box width, Q32.32
  assign mag   = d_r[32] ? 33'(-d_r) : 33'(d_r);
  assign p_nxt = P_W'(mag) * P_W'(inv_i);

  // stage 3: clamp box index, position inside the box
  assign idx  = p_r[64:32];
  assign nbm1 = nb_i - NB_W'(1);
  assign q16  = p_r[64:16];
  assign mneg = q16 + 49'(p_r[15:0] != 16'd0);

  always_comb begin
    if (neg_r) begin
      box_nxt = '0;
      if (mneg > U_LIM) u_nxt = U_W'(-(64'sd1 <<< 22));
      else              u_nxt = U_W'(-mneg);
      upos = '0;
    end else begin
      if (idx > 33'(nbm1)) box_nxt = BX_W'(nbm1);
      else                 box_nxt = idx[BX_W-1:0];
      upos = q16 - {33'(box_nxt), 16'd0};
      if (upos >= U_LIM) u_nxt = U_W'(U_LIM - 49'd1);
      else               u_nxt = upos[U_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_nxt;
      neg_r <= d_r[32];
      p_r   <= p_nxt;
      box_r <= box_nxt;
      u_r   <= u_nxt;
    end
  end

  assign valid_o = v3_r;
  assign box_o   = box_r;
  assign u_o     = u_r;

endmodule

`default_nettype wire

FILE: rtl/core/lgsw_basis.sv
// lgsw_basis: pipelined lagrange basis values for one axis, one
// numerator factor per stage, then constant division; depends on lgsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgsw_basis #(
  parameter int NODES = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [lgsw_pkg::U_W-1:0]   u_i,
  output logic                              valid_o,
  output logic signed [lgsw_pkg::BASIS_W-1:0] l_o [NODES]
);
  import lgsw_pkg::*;

  localparam int STG = NODES - 1;
  localparam int NW  = ACC_W + 1;
  localparam int RW  = NW + 2;
  localparam int PW  = NW + RW + 1;
  localparam int LO_W = NW / 2;
  localparam logic signed [63:0] ACC_LIM = (64'sd1 <<< 35) - 64'sd1;
  localparam logic signed [NW:0] B_LIM   = (NW+1)'((64'sd1 <<< 31) - 64'sd1);

  logic signed [V_W-1:0]   v_r   [STG];
  logic signed [ACC_W-1:0] acc_r [STG][NODES];
  logic                    sv_r  [STG];
  logic signed [V_W-1:0]   v_nxt;
  logic                    dv1_r, dv2_r, dv3_r;

  // numerator stage 0: node offset scaled to 2*NODES*u
  assign v_nxt = V_W'(u_i) * V_W'(2 * NODES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STG; i++) sv_r[i] <= 1'b0;
      dv1_r <= 1'b0;
      dv2_r <= 1'b0;
      dv3_r <= 1'b0;
    end else if (en) begin
      sv_r[0] <= valid_i;
      for (int i = 1; i < STG; i++) sv_r[i] <= sv_r[i-1];
      dv1_r <= sv_r[STG-1];
      dv2_r <= dv1_r;
      dv3_r <= dv2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= v_nxt;
      for (int i = 1; i < STG; i++) v_r[i] <= v_r[i-1];
    end
  end

  for (genvar j = 0; j < NODES; j++) begin : g_lane
    localparam longint DM   = den_mag(j, NODES);
    localparam int     SH   = NW + $clog2(2 * DM);
    localparam logic [RW-1:0] RECIP = RW'(((PW'(1) << SH) / (2 * DM)) + 1);
    localparam logic   DNEG = ((NODES - 1 - j) % 2) == 1;
    localparam int     K0   = (j == 0) ? 1 : 0;
    localparam logic signed [V_W-1:0] OFS0 = V_W'((2 * K0 + 1) << 16);

    logic [NW-1:0]        n_r;
    logic                 neg1_r, neg2_r;
    logic [NW-LO_W+RW-1:0] pph_r;
    logic [LO_W+RW-1:0]   ppl_r;
    logic signed [BASIS_W-1:0] l_r;
    logic [ACC_W-2:0]     m;
    logic [PW-1:0]        sum;
    logic signed [NW:0]   qs;
    logic signed [BASIS_W-1:0] l_nxt;

    // first factor is exact, no rounding needed
    always_ff @(posedge clk) begin
      if (en) acc_r[0][j] <= ACC_W'(v_nxt - OFS0);
    end

    // one rounded, saturated factor per stage
    for (genvar i = 1; i < STG; i++) begin : g_step
      localparam int KI = (i < j) ? i : i + 1;
      localparam logic signed [V_W-1:0] OFS = V_W'((2 * KI + 1) << 16);
      logic signed [V_W-1:0]   f;
      logic signed [63:0]      prod, rnd;
      logic signed [ACC_W-1:0] acc_nxt;
      assign f    = v_r[i-1] - OFS;
      assign prod = 64'(acc_r[i-1][j]) * 64'(f);
      assign rnd  = (prod + 64'sd32768) >>> 16;
      always_comb begin
        if (rnd > ACC_LIM)       acc_nxt = ACC_W'(ACC_LIM);
        else if (rnd < -ACC_LIM) acc_nxt = ACC_W'(-ACC_LIM);
        else                     acc_nxt = rnd[ACC_W-1:0];
      end
      always_ff @(posedge clk) begin
        if (en) acc_r[i][j] <= acc_nxt;
      end
    end

    // division by the constant denominator, rounded half away from zero
    assign m   = acc_r[STG-1][j][ACC_W-1] ? (ACC_W-1)'(-acc_r[STG-1][j])
                                          : acc_r[STG-1][j][ACC_W-2:0];
    assign sum = PW'(ppl_r) + (PW'(pph_r) << LO_W);
    assign qs  = neg2_r ? -$signed({1'b0, NW'(sum >> SH)})
                        : $signed({1'b0, NW'(sum >> SH)});

    always_comb begin
      if (qs > B_LIM)       l_nxt = BASIS_W'(B_LIM);
      else if (qs < -B_LIM) l_nxt = BASIS_W'(-B_LIM);
      else                  l_nxt = qs[BASIS_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r    <= {1'b0, m, 1'b0} + NW'(DM);
        neg1_r <= acc_r[STG-1][j][ACC_W-1] ^ DNEG;
        ppl_r  <= (LO_W+RW)'(n_r[LO_W-1:0]) * (LO_W+RW)'(RECIP);
        pph_r  <= (NW-LO_W+RW)'(n_r[NW-1:LO_W]) * (NW-LO_W+RW)'(RECIP);
        neg2_r <= neg1_r;
        l_r    <= l_nxt;
      end
    end

    assign l_o[j] = l_r;
  end

  assign valid_o = dv3_r;

endmodule

`default_nettype wire

FILE: rtl/core/lgsw_emit.sv
// lgsw_emit: walks the node pairs of one point, multiplies the basis
// values and drives the result stream; depends on lgsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgsw_emit #(
  parameter int NODES = 3,
  parameter int MAX_BOXES = 32,
  localparam int NB_W = $clog2(MAX_BOXES + 1),
  localparam int BX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               pt_valid,
  output logic                               pt_ready,
  input  logic [BX_W-1:0]                    bx_i,
  input  logic [BX_W-1:0]                    by_i,
  input  logic                               last_i,
  input  logic signed [lgsw_pkg::BASIS_W-1:0] lx_i [NODES],
  input  logic signed [lgsw_pkg::BASIS_W-1:0] ly_i [NODES],
  input  logic [NB_W-1:0]                    nb_i,
  output logic                               o_valid,
  input  logic                               o_ready,
  output logic [lgsw_pkg::GIDX_W-1:0]        o_index,
  output logic signed [lgsw_pkg::WEIGHT_W-1:0] o_weight,
  output logic                               o_last,
  output logic                               o_end
);
  import lgsw_pkg::*;

  localparam int A_W  = $clog2(NODES);
  localparam int RW   = $clog2(MAX_BOXES * NODES + 1);
  localparam int SW   = (2 * RW + 1 > GIDX_W) ? 2 * RW + 1 : GIDX_W;
  localparam logic signed [47:0] W_MAX = 48'sd524287;
  localparam logic signed [47:0] W_MIN = -48'sd524288;

  logic                      busy_r;
  logic [A_W-1:0]            a_r, b_r;
  logic [BX_W-1:0]           bx_r, by_r;
  logic                      last_r;
  logic signed [BASIS_W-1:0] lx_r [NODES];
  logic signed [BASIS_W-1:0] ly_r [NODES];
  logic                      e1_v_r, e1_last_r, e1_end_r;
  logic signed [63:0]        prod_r;
  logic [GIDX_W-1:0]         e1_idx_r;
  logic                      o_v_r, o_last_r, o_end_r;
  logic [GIDX_W-1:0]         o_idx_r;
  logic signed [WEIGHT_W-1:0] o_w_r, w_nxt;
  logic                      out_ok, e1_ok, issue, at_end;
  logic [RW-1:0]             row, cols, col;
  logic [SW-1:0]             idx_nxt;
  logic signed [47:0]        rnd;

  // handshake between the pair walker and the two result stages
  assign out_ok   = !o_v_r || o_ready;
  assign e1_ok    = !e1_v_r || out_ok;
  assign issue    = busy_r && e1_ok;
  assign at_end   = (a_r == A_W'(NODES - 1)) && (b_r == A_W'(NODES - 1));
  assign pt_ready = !busy_r || (issue && at_end);

  // pair counters, x node outer and y node inner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      a_r    <= '0;
      b_r    <= '0;
    end else if (pt_ready) begin
      busy_r <= pt_valid;
      a_r    <= '0;
      b_r    <= '0;
    end else if (issue) begin
      if (b_r == A_W'(NODES - 1)) begin
        b_r <= '0;
        a_r <= a_r + A_W'(1);
      end else begin
        b_r <= b_r + A_W'(1);
      end
    end
  end

  // point held while its pairs go out
  always_ff @(posedge clk) begin
    if (pt_ready && pt_valid) begin
      bx_r   <= bx_i;
      by_r   <= by_i;
      last_r <= last_i;
      lx_r   <= lx_i;
      ly_r   <= ly_i;
    end
  end

  // global grid index of the node pair
  assign row     = RW'(bx_r) * RW'(NODES) + RW'(a_r);
  assign cols    = RW'(nb_i) * RW'(NODES);
  assign col     = RW'(by_r) * RW'(NODES) + RW'(b_r);
  assign idx_nxt = SW'(row) * SW'(cols) + SW'(col);

  // stage e1: basis product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else if (e1_ok) begin
      e1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (e1_ok) begin
      prod_r    <= 64'(lx_r[a_r]) * 64'(ly_r[b_r]);
      e1_idx_r  <= idx_nxt[GIDX_W-1:0];
      e1_last_r <= at_end;
      e1_end_r  <= at_end && last_r;
    end
  end

  // stage out: round to Q.16 and saturate
  assign rnd = 48'((prod_r + 64'sd32768) >>> 16);
  always_comb begin
    if (rnd > W_MAX)      w_nxt = WEIGHT_W'(W_MAX);
    else if (rnd < W_MIN) w_nxt = WEIGHT_W'(W_MIN);
    else                  w_nxt = rnd[WEIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (out_ok) begin
      o_v_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ok) begin
      o_idx_r  <= e1_idx_r;
      o_w_r    <= w_nxt;
      o_last_r <= e1_last_r;
      o_end_r  <= e1_end_r;
    end
  end

  assign o_valid  = o_v_r;
  assign o_index  = o_idx_r;
  assign o_weight = o_w_r;
  assign o_last   = o_last_r;
  assign o_end    = o_end_r;

endmodule

`default_nettype wire

FILE: rtl/core/lagrange_grid_spread_weights_top.sv
// lagrange_grid_spread_weights_top: configuration registers, per-axis
// locate and basis pipelines, result emitter; depends on lgsw_pkg
`timescale 1ns / 1ps
`default_nettype none

// Spreads one 2-D Q16.16 point onto a NODES x NODES patch of grid nodes.
// Each accepted point yields NODES*NODES results (nine by default), one per
// clock on the output stream while out_tready holds, x node outer and y node
// inner; the emitter walks one pair per cycle unless stalled and takes the
// next point only as the last pair of the current one issues. The front
// pipeline (three locate stages, NODES-1 numerator stages, three division
// stages) holds further points meanwhile. The first result of a point passes
// through the NODES+5 front stages, the emitter's point register and two
// result stages. Configuration writes are accepted every cycle and should
// only be made while no points are in flight.
module lagrange_grid_spread_weights_top #(
  parameter int NODES = 3,
  parameter int MAX_BOXES = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lgsw_pkg::IN_DATA_W-1:0]      in_tdata,   // x_coord, y_coord
  input  logic                                in_tlast,   // last_point
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lgsw_pkg::OUT_DATA_W-1:0]     out_tdata,  // grid_index, weight, pad
  output logic                                out_tlast,  // last_of_run
  output logic                                out_tuser,  // end_of_set
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lgsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lgsw_pkg::CFG_W-1:0]          cfg_data
);
  import lgsw_pkg::*;

  localparam int NB_W = $clog2(MAX_BOXES + 1);
  localparam int BX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int LAT  = 3 + (NODES - 1) + 3;

  logic [CFG_W-1:0]   origin_r, inv_r;
  logic [NBCFG_W-1:0] nbc_r;
  logic [NB_W-1:0]    nb;
  logic               adv;
  logic               lx_v, ly_v, bx_v, by_v;
  logic [BX_W-1:0]    box_x, box_y;
  logic signed [U_W-1:0] u_x, u_y;
  logic signed [BASIS_W-1:0] l_x [NODES];
  logic signed [BASIS_W-1:0] l_y [NODES];
  logic               pt_ready;
  logic [LAT-1:0]     last_r;
  logic [BX_W-1:0]    bxd_r [NODES + 2];
  logic [BX_W-1:0]    byd_r [NODES + 2];
  logic [GIDX_W-1:0]  o_index;
  logic signed [WEIGHT_W-1:0] o_weight;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      inv_r    <= CFG_W'(65536);
      nbc_r    <= NBCFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_ORIGIN:    origin_r <= cfg_data;
        REG_INV_BOX_WIDTH:  inv_r    <= cfg_data;
        REG_BOXES_PER_SIDE: nbc_r    <= cfg_data[NBCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // boxes per side clamped to [1, MAX_BOXES]
  always_comb begin
    if (nbc_r == '0)                            nb = NB_W'(1);
    else if ({1'b0, nbc_r} > 7'(MAX_BOXES))     nb = NB_W'(MAX_BOXES);
    else                                        nb = NB_W'(nbc_r);
  end

  // whole front pipeline moves together
  assign adv       = !lx_v || pt_ready;
  assign in_tready = adv;

  lgsw_locate #(.MAX_BOXES(MAX_BOXES)) u_loc_x (
    .clk, .rst_n, .en(adv), .valid_i(in_tvalid),
    .coord_i(in_tdata[31:0]), .origin_i(origin_r), .inv_i(inv_r), .nb_i(nb),
    .valid_o(bx_v), .box_o(box_x), .u_o(u_x)
  );

  lgsw_locate #(.MAX_BOXES(MAX_BOXES)) u_loc_y (
    .clk, .rst_n, .en(adv), .valid_i(in_tvalid),
    .coord_i(in_tdata[63:32]), .origin_i(origin_r), .inv_i(inv_r), .nb_i(nb),
    .valid_o(by_v), .box_o(box_y), .u_o(u_y)
  );

  lgsw_basis #(.NODES(NODES)) u_bas_x (
    .clk, .rst_n, .en(adv), .valid_i(bx_v), .u_i(u_x), .valid_o(lx_v), .l_o(l_x)
  );

  lgsw_basis #(.NODES(NODES)) u_bas_y (
    .clk, .rst_n, .en(adv), .valid_i(by_v), .u_i(u_y), .valid_o(ly_v), .l_o(l_y)
  );

  // side data delayed alongside the basis stages
  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= {last_r[LAT-2:0], in_tlast};
      bxd_r[0] <= box_x;
      byd_r[0] <= box_y;
      for (int i = 1; i < NODES + 2; i++) begin
        bxd_r[i] <= bxd_r[i-1];
        byd_r[i] <= byd_r[i-1];
      end
    end
  end

  lgsw_emit #(.NODES(NODES), .MAX_BOXES(MAX_BOXES)) u_emit (
    .clk, .rst_n,
    .pt_valid(lx_v && ly_v), .pt_ready,
    .bx_i(bxd_r[NODES+1]), .by_i(byd_r[NODES+1]), .last_i(last_r[LAT-1]),
    .lx_i(l_x), .ly_i(l_y), .nb_i(nb),
    .o_valid(out_tvalid), .o_ready(out_tready),
    .o_index, .o_weight, .o_last(out_tlast), .o_end(out_tuser)
  );

  assign out_tdata = {6'd0, o_weight, o_index};

endmodule

`default_nettype wire

FILE: rtl/core/lgsw_checker.sv
// lgsw_checker: port-level assertions on the result stream
// bound to lagrange_grid_spread_weights_top; depends on lgsw_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgsw_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [lgsw_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire                              out_tlast,
  input wire                              out_tuser
);

  // end of set only on the final pair of a point
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast || !out_tuser))
    else $error("end_of_set without last_of_run");

  // reset empties the result stage
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled transaction holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

bind lagrange_grid_spread_weights_top lgsw_checker u_lgsw_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
);

`default_nettype wire
